// ===== rtl/vst_pkg.sv =====
`default_nettype none
package vst_pkg;

    localparam int unsigned DEPTH_FRAC = 16;

    typedef enum logic [1:0] {
        MODE_LOAD_MV   = 2'd0,
        MODE_LOAD_PROJ = 2'd1,
        MODE_VERTEX    = 2'd2,
        MODE_UNUSED    = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        REG_LEFT   = 3'd0,
        REG_TOP    = 3'd1,
        REG_WIDTH  = 3'd2,
        REG_HEIGHT = 3'd3,
        REG_NEAR   = 3'd4,
        REG_FAR    = 3'd5
    } t_reg;

    typedef struct packed {
        logic [1:0]         mode;
        logic [3:0]         entry_index;
        logic signed [31:0] entry_value;
        logic signed [31:0] vertex_x;
        logic signed [31:0] vertex_y;
        logic signed [31:0] vertex_z;
        logic signed [31:0] vertex_w;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] screen_x;
        logic signed [31:0] screen_y;
        logic signed [31:0] screen_depth;
        logic signed [31:0] recip_w;
        logic               w_zero;
    } t_out_word;

    function automatic logic signed [31:0] sat32(input logic signed [95:0] x);
        if (x > 96'sh7FFFFFFF) begin
            return 32'sh7FFFFFFF;
        end else if (x < -96'sh80000000) begin
            return -32'sh80000000;
        end
        return x[31:0];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/vst_lane.sv =====
`default_nettype none
// One multiply lane: a signed 32x32 product, registered, then floor-shifted.
module vst_lane #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic signed [31:0] i_a,
    input  wire logic signed [31:0] i_b,
    output logic signed [63:0]      o_p
);
    logic signed [63:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_p = r_prod >>> FRAC_BITS;
endmodule
`default_nettype wire

// ===== rtl/vst_div.sv =====
`default_nettype none
// Restoring divider: 2^(2F) / d, truncated toward zero, one quotient bit a cycle.
module vst_div #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [31:0] i_den,
    output logic                    o_done,
    output logic signed [31:0]      o_quot
);
    localparam int NB = 2 * FRAC_BITS + 1;
    localparam int CW = $clog2(NB + 1);

    logic [NB-1:0] r_num;
    logic [NB-1:0] r_q;
    logic [32:0]   r_rem;
    logic [31:0]   r_den;
    logic          r_neg;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [33:0]   w_try;
    logic signed [NB+1:0] w_sq;

    assign w_try = {r_rem, r_num[NB-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NB);
                r_num  <= NB'(1) << (2 * FRAC_BITS);
                r_rem  <= '0;
                r_q    <= '0;
                r_neg  <= i_den[31];
                r_den  <= i_den[31] ? 32'(-i_den) : 32'(i_den);
            end else if (r_busy) begin
                r_num <= r_num << 1;
                if (w_try >= {2'b00, r_den}) begin
                    r_rem <= 33'(w_try - {2'b00, r_den});
                    r_q   <= {r_q[NB-2:0], 1'b1};
                end else begin
                    r_rem <= w_try[32:0];
                    r_q   <= {r_q[NB-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign w_sq   = r_neg ? -$signed({2'b00, r_q}) : $signed({2'b00, r_q});
    assign o_done = r_done;
    assign o_quot = vst_pkg::sat32(96'(w_sq));
endmodule
`default_nettype wire

// ===== rtl/vertex_to_screen_transform.sv =====
`default_nettype none
// Vertex to screen transform. Load words (mode 0/1) write one modelview or
// projection entry at the accepting edge and return nothing; loads can be taken
// every cycle while idle. A vertex word passes these steps before its result is
// valid: four multiply lanes form one entry of projection*modelview at a time
// (S_TMUL, S_TACC), then clip coordinates one row at a time (S_CMUL, S_CACC), then
// a bit-serial divider gives 1/w (S_DIV), then the lanes scale x, y, z by 1/w
// (S_NMUL) and S_OUT maps them to the viewport. A zero clip w skips the divider.
// Words are taken only while idle, so the block takes no new word while a vertex
// is in work. The result sits in an output register, so the next word is taken
// while it waits; a later vertex holds in its last stage until that register frees.
module vertex_to_screen_transform #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire vst_pkg::t_in_word  i_data,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output vst_pkg::t_out_word      o_data,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [16:0]        i_cfg_data
);
    localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

    typedef enum logic [7:0] {
        S_IDLE = 8'b00000001,
        S_TMUL = 8'b00000010,
        S_TACC = 8'b00000100,
        S_CMUL = 8'b00001000,
        S_CACC = 8'b00010000,
        S_DIV  = 8'b00100000,
        S_NMUL = 8'b01000000,
        S_OUT  = 8'b10000000
    } t_state;

    t_state r_state;
    logic signed [31:0] r_mv [16];
    logic signed [31:0] r_pj [16];
    logic signed [31:0] r_t  [16];
    logic signed [31:0] r_v  [4];
    logic signed [31:0] r_clip [4];
    logic [3:0] r_cnt;
    logic signed [14:0] r_left, r_top;
    logic [14:0] r_width, r_height;
    logic [16:0] r_near, r_far;
    logic signed [31:0] r_rhw;
    logic signed [31:0] r_n [3];
    logic r_wzero;
    vst_pkg::t_out_word r_out;
    logic r_ovalid;

    logic signed [31:0] w_a [4];
    logic signed [31:0] w_b [4];
    logic signed [63:0] w_p [4];
    logic signed [95:0] w_sum;
    logic w_div_done;
    logic signed [31:0] w_quot;
    logic w_accept;
    logic signed [33:0] w_nearq, w_farq;
    logic [1:0] w_r, w_c;

    assign w_r = r_cnt[3:2];
    assign w_c = r_cnt[1:0];
    assign o_ready  = (r_state == S_IDLE);
    assign w_accept = i_valid && o_ready;

    genvar g;
    generate
        for (g = 0; g < 4; g++) begin : g_lane
            vst_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
                .i_clk(i_clk), .i_a(w_a[g]), .i_b(w_b[g]), .o_p(w_p[g])
            );
        end
    endgenerate

    // Lane operand select per phase.
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_a[k] = '0;
            w_b[k] = '0;
        end
        unique case (r_state)
            S_TMUL: begin
                for (int k = 0; k < 4; k++) begin
                    w_a[k] = r_pj[{2'(k), w_r}];
                    w_b[k] = r_mv[{w_c, 2'(k)}];
                end
            end
            S_CMUL: begin
                for (int k = 0; k < 4; k++) begin
                    w_a[k] = r_t[{w_r, 2'(k)}];
                    w_b[k] = r_v[k];
                end
            end
            S_DIV: begin
                for (int k = 0; k < 3; k++) begin
                    w_a[k] = r_clip[k];
                    w_b[k] = w_quot;
                end
            end
            default: begin
            end
        endcase
    end

    assign w_sum = 96'(w_p[0]) + 96'(w_p[1]) + 96'(w_p[2]) + 96'(w_p[3]);

    vst_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_start(r_state == S_CACC && w_r == 2'd3 && vst_pkg::sat32(w_sum) != 32'sd0),
        .i_den(vst_pkg::sat32(w_sum)),
        .o_done(w_div_done), .o_quot(w_quot)
    );

    generate
        if (FRAC_BITS >= vst_pkg::DEPTH_FRAC) begin : g_dsh
            assign w_nearq = 34'($signed({1'b0, r_near})) <<< (FRAC_BITS - vst_pkg::DEPTH_FRAC);
            assign w_farq  = 34'($signed({1'b0, r_far}))  <<< (FRAC_BITS - vst_pkg::DEPTH_FRAC);
        end else begin : g_dsh
            assign w_nearq = 34'($signed({1'b0, r_near})) >>> (vst_pkg::DEPTH_FRAC - FRAC_BITS);
            assign w_farq  = 34'($signed({1'b0, r_far}))  >>> (vst_pkg::DEPTH_FRAC - FRAC_BITS);
        end
    endgenerate

    // Viewport stage products (33x16 and 32x35 bits: stay within one multiplier each).
    logic signed [63:0] w_sxp, w_syp;
    logic signed [95:0] w_szp;
    logic signed [95:0] w_sx, w_sy, w_sz;
    assign w_sxp = (64'(ONE) + 64'(r_n[0])) * $signed({1'b0, r_width});
    assign w_syp = (64'(ONE) - 64'(r_n[1])) * $signed({1'b0, r_height});
    assign w_szp = 96'(r_n[2]) * 96'(w_farq - w_nearq);
    assign w_sx = 96'(w_sxp >>> 1) + (96'(r_left) <<< FRAC_BITS);
    assign w_sy = 96'(w_syp >>> 1) + (96'(r_top) <<< FRAC_BITS);
    assign w_sz = (w_szp >>> FRAC_BITS) + 96'(w_nearq);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_left <= '0; r_top <= '0;
            r_width <= 15'd640; r_height <= 15'd480;
            r_near <= '0; r_far <= 17'd65536;
            for (int k = 0; k < 16; k++) begin
                r_mv[k] <= (k % 5 == 0) ? ONE : 32'sd0;
                r_pj[k] <= (k % 5 == 0) ? ONE : 32'sd0;
            end
        end else begin
            // S_OUT sets valid itself when it hands over a new word
            if (o_valid && i_ready && r_state != S_OUT) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    vst_pkg::REG_LEFT:   r_left   <= i_cfg_data[14:0];
                    vst_pkg::REG_TOP:    r_top    <= i_cfg_data[14:0];
                    vst_pkg::REG_WIDTH:  r_width  <= i_cfg_data[14:0];
                    vst_pkg::REG_HEIGHT: r_height <= i_cfg_data[14:0];
                    vst_pkg::REG_NEAR:   r_near   <= i_cfg_data;
                    vst_pkg::REG_FAR:    r_far    <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        unique case (i_data.mode)
                            vst_pkg::MODE_LOAD_MV:   r_mv[i_data.entry_index] <= i_data.entry_value;
                            vst_pkg::MODE_LOAD_PROJ: r_pj[i_data.entry_index] <= i_data.entry_value;
                            vst_pkg::MODE_VERTEX: begin
                                r_v[0] <= i_data.vertex_x;
                                r_v[1] <= i_data.vertex_y;
                                r_v[2] <= i_data.vertex_z;
                                r_v[3] <= i_data.vertex_w;
                                r_cnt  <= '0;
                                r_state <= S_TMUL;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_TMUL: r_state <= S_TACC;
                S_TACC: begin
                    r_t[{w_r, w_c}] <= vst_pkg::sat32(w_sum);
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 4'd15) begin
                        r_state <= S_CMUL;
                        r_cnt <= '0;
                    end else begin
                        r_state <= S_TMUL;
                    end
                end
                S_CMUL: r_state <= S_CACC;
                S_CACC: begin
                    r_clip[w_r] <= vst_pkg::sat32(w_sum);
                    r_cnt <= r_cnt + 4'd4;
                    if (w_r == 2'd3) begin
                        if (vst_pkg::sat32(w_sum) == 32'sd0) begin
                            r_wzero  <= 1'b1;
                            r_state  <= S_OUT;
                        end else begin
                            r_wzero <= 1'b0;
                            r_state <= S_DIV;
                        end
                    end else begin
                        r_state <= S_CMUL;
                    end
                end
                S_DIV: begin
                    // Quotient holds after done; S_NMUL reads the lane products.
                    if (w_div_done) begin
                        r_rhw   <= w_quot;
                        r_state <= S_NMUL;
                    end
                end
                S_NMUL: begin
                    for (int k = 0; k < 3; k++) begin
                        r_n[k] <= vst_pkg::sat32(96'(w_p[k]));
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // hold until the output register is free
                    if (!r_ovalid || i_ready) begin
                        if (r_wzero) begin
                            r_out <= '{w_zero: 1'b1, default: '0};
                        end else begin
                            r_out.screen_x     <= vst_pkg::sat32(w_sx);
                            r_out.screen_y     <= vst_pkg::sat32(w_sy);
                            r_out.screen_depth <= vst_pkg::sat32(w_sz);
                            r_out.recip_w      <= r_rhw;
                            r_out.w_zero       <= 1'b0;
                        end
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_out;

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> r_state == S_IDLE) else $error("ready outside idle");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data)) else $error("result dropped");
    a_zero_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.w_zero |-> o_data.recip_w == 32'sd0) else $error("w_zero data");
endmodule
`default_nettype wire

// ===== test/testbench.sv =====
module testbench;

    localparam int FRAC = 16;
    localparam longint ONE = 64'sd1 << FRAC;
    localparam int CYCLE_LIMIT = 900000;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    vst_pkg::t_in_word      in_word;
    logic                   out_valid;
    logic                   out_ready;
    vst_pkg::t_out_word     out_word;
    logic                   cfg_we;
    logic [2:0]             cfg_index;
    logic [16:0]            cfg_data;

    vertex_to_screen_transform u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_valid     (in_valid),
        .o_ready     (in_ready),
        .i_data      (in_word),
        .o_valid     (out_valid),
        .i_ready     (out_ready),
        .o_data      (out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // predictor state
    longint vp_left, vp_top, vp_width, vp_height, z_near, z_far;
    logic signed [31:0] mv_mat [16];
    logic signed [31:0] proj_mat [16];

    vst_pkg::t_in_word  pending_words [$];
    vst_pkg::t_out_word expected_pixels [$];
    int        failures;
    int        cycle_count;
    bit        calm_phase;
    int        hold_off_left;
    bit        hold_off_armed;

    always begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic longint floor_shift(longint x, int s);
        return x >>> s;
    endfunction

    function automatic longint clamp32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    task automatic reset_model();
        vp_left = 0; vp_top = 0; vp_width = 640; vp_height = 480;
        z_near = 0; z_far = 65536;
        for (int k = 0; k < 16; k++) begin
            mv_mat[k] = (k % 5 == 0) ? 32'sh10000 : 32'sh0;
            proj_mat[k] = (k % 5 == 0) ? 32'sh10000 : 32'sh0;
        end
    endtask

    task automatic model_register(vst_pkg::t_reg idx, logic [16:0] val);
        case (idx)
            vst_pkg::REG_LEFT:   vp_left = longint'($signed(val[14:0]));
            vst_pkg::REG_TOP:    vp_top = longint'($signed(val[14:0]));
            vst_pkg::REG_WIDTH:  vp_width = longint'(val[14:0]);
            vst_pkg::REG_HEIGHT: vp_height = longint'(val[14:0]);
            vst_pkg::REG_NEAR:   z_near = longint'(val);
            vst_pkg::REG_FAR:    z_far = longint'(val);
            default: ;
        endcase
    endtask

    // apply one accepted word to the matrices and queue the pixel it yields
    task automatic project_word(vst_pkg::t_in_word w);
        longint xf [4][4];
        longint clip [4];
        longint v [4];
        longint acc, rhw, nx, ny, nz;
        vst_pkg::t_out_word r;
        case (vst_pkg::t_mode'(w.mode))
            vst_pkg::MODE_LOAD_MV:   mv_mat[w.entry_index] = w.entry_value;
            vst_pkg::MODE_LOAD_PROJ: proj_mat[w.entry_index] = w.entry_value;
            vst_pkg::MODE_VERTEX: begin
                v[0] = longint'(w.vertex_x); v[1] = longint'(w.vertex_y);
                v[2] = longint'(w.vertex_z); v[3] = longint'(w.vertex_w);
                for (int row = 0; row < 4; row++)
                    for (int col = 0; col < 4; col++) begin
                        acc = 0;
                        for (int i = 0; i < 4; i++)
                            acc += floor_shift(longint'(proj_mat[row + 4 * i]) *
                                               longint'(mv_mat[i + 4 * col]), FRAC);
                        xf[row][col] = clamp32(acc);
                    end
                for (int row = 0; row < 4; row++) begin
                    acc = 0;
                    for (int col = 0; col < 4; col++)
                        acc += floor_shift(xf[row][col] * v[col], FRAC);
                    clip[row] = clamp32(acc);
                end
                r = '0;
                if (clip[3] == 0) begin
                    r.w_zero = 1'b1;
                end else begin
                    rhw = clamp32((64'sd1 <<< (2 * FRAC)) / clip[3]);
                    nx = clamp32(floor_shift(clip[0] * rhw, FRAC));
                    ny = clamp32(floor_shift(clip[1] * rhw, FRAC));
                    nz = clamp32(floor_shift(clip[2] * rhw, FRAC));
                    r.screen_x = 32'(clamp32(floor_shift((ONE + nx) * vp_width, 1) +
                                             vp_left * ONE));
                    r.screen_y = 32'(clamp32(floor_shift((ONE - ny) * vp_height, 1) +
                                             vp_top * ONE));
                    r.screen_depth = 32'(clamp32(floor_shift(nz * (z_far - z_near), FRAC) +
                                                 z_near));
                    r.recip_w = 32'(rhw);
                end
                expected_pixels.push_back(r);
            end
            default: ;
        endcase
    endtask

    // driver
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_ready) begin
            if (in_valid) project_word(in_word);
            if (pending_words.size() > 0 && (calm_phase || $urandom_range(99) >= 26)) begin
                in_word <= pending_words.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk) begin
        vst_pkg::t_out_word e;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_pixels.size() == 0) begin
                    $error("unexpected word %h", out_word);
                    failures++;
                end else begin
                    e = expected_pixels.pop_front();
                    if (out_word.screen_x !== e.screen_x) begin
                        $error("screen_x exp %0d got %0d", e.screen_x, out_word.screen_x);
                        failures++;
                    end
                    if (out_word.screen_y !== e.screen_y) begin
                        $error("screen_y exp %0d got %0d", e.screen_y, out_word.screen_y);
                        failures++;
                    end
                    if (out_word.screen_depth !== e.screen_depth) begin
                        $error("screen_depth exp %0d got %0d", e.screen_depth,
                               out_word.screen_depth);
                        failures++;
                    end
                    if (out_word.recip_w !== e.recip_w) begin
                        $error("recip_w exp %0d got %0d", e.recip_w, out_word.recip_w);
                        failures++;
                    end
                    if (out_word.w_zero !== e.w_zero) begin
                        $error("w_zero exp %0d got %0d", e.w_zero, out_word.w_zero);
                        failures++;
                    end
                end
            end
            if (hold_off_armed && hold_off_left > 0) begin
                hold_off_left <= hold_off_left - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= calm_phase || $urandom_range(99) >= 26;
            end
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic logic signed [31:0] rand_q();
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'sh80000000 + $urandom_range(3);
            2: return 32'sh7FFFFFFF - $urandom_range(3);
            default: return $signed($urandom_range(2 * 65536 * 4)) - 32'sd262144;
        endcase
    endfunction

    function automatic vst_pkg::t_in_word make_word(vst_pkg::t_mode m, int idx,
                                                    logic signed [31:0] val);
        vst_pkg::t_in_word w;
        w.mode = m;
        w.entry_index = 4'(idx);
        w.entry_value = val;
        w.vertex_x = $urandom; w.vertex_y = $urandom;
        w.vertex_z = $urandom; w.vertex_w = $urandom;
        return w;
    endfunction

    function automatic vst_pkg::t_in_word make_vertex(longint x, longint y, longint z,
                                                      longint w4);
        vst_pkg::t_in_word w;
        w = make_word(vst_pkg::MODE_VERTEX, $urandom_range(15), $urandom);
        w.vertex_x = 32'(x); w.vertex_y = 32'(y); w.vertex_z = 32'(z); w.vertex_w = 32'(w4);
        return w;
    endfunction

    // drain: wait until every queued word has gone and all pixels are back
    task automatic drain();
        while (pending_words.size() > 0 || in_valid || expected_pixels.size() > 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic write_reg(vst_pkg::t_reg idx, logic [16:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        model_register(idx, val);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_phase(int n);
        int k;
        for (k = 0; k < n; k++) begin
            case ($urandom_range(9))
                0, 1: pending_words.push_back(make_word(vst_pkg::MODE_LOAD_MV,
                                                        $urandom_range(15), rand_q()));
                2, 3: pending_words.push_back(make_word(vst_pkg::MODE_LOAD_PROJ,
                                                        $urandom_range(15), rand_q()));
                4: pending_words.push_back(make_word(vst_pkg::MODE_UNUSED,
                                                     $urandom_range(15), $urandom));
                5: pending_words.push_back(make_vertex(rand_q(), rand_q(), rand_q(), 0));
                6: pending_words.push_back(make_vertex($urandom, $urandom, $urandom,
                                                       $urandom));
                default: pending_words.push_back(make_vertex(rand_q(), rand_q(), rand_q(),
                                                             rand_q()));
            endcase
        end
    endtask

    initial begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_word = '0;
        out_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = vst_pkg::REG_LEFT;
        cfg_data = '0;
        failures = 0;
        cycle_count = 0;
        calm_phase = 1'b0;
        hold_off_left = 0;
        hold_off_armed = 1'b0;
        reset_model();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: identity, zero w, extremes, unused mode
        pending_words.push_back(make_vertex(0, 0, 0, ONE));
        pending_words.push_back(make_vertex(ONE / 2, -ONE / 2, ONE, ONE));
        pending_words.push_back(make_vertex(5, 6, 7, 0));
        pending_words.push_back(make_vertex(32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 1));
        pending_words.push_back(make_vertex(32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000,
                                            -1));
        pending_words.push_back(make_vertex(-1, -1, -1, 32'sh80000000));
        pending_words.push_back(make_vertex(3, 3, 3, 32'sh7FFFFFFF));
        pending_words.push_back(make_word(vst_pkg::MODE_UNUSED, 15, 32'sh7FFFFFFF));
        pending_words.push_back(make_word(vst_pkg::MODE_LOAD_MV, 15, 32'sh20000));
        pending_words.push_back(make_word(vst_pkg::MODE_LOAD_PROJ, 0, 32'sh80000000));
        pending_words.push_back(make_word(vst_pkg::MODE_LOAD_PROJ, 0, 32'sh7FFFFFFF));
        pending_words.push_back(make_vertex(ONE, ONE, ONE, ONE));
        pending_words.push_back(make_word(vst_pkg::MODE_LOAD_MV, 0, 32'sh0));
        pending_words.push_back(make_vertex(ONE, 2 * ONE, -ONE, 4 * ONE));
        pending_words.push_back(make_word(vst_pkg::MODE_LOAD_PROJ, 0, 32'sh10000));
        pending_words.push_back(make_word(vst_pkg::MODE_LOAD_MV, 0, 32'sh10000));
        pending_words.push_back(make_word(vst_pkg::MODE_LOAD_MV, 15, 32'sh10000));
        drain();

        // extremes of the viewport and a reversed depth range
        write_reg(vst_pkg::REG_LEFT, 17'h04000);
        write_reg(vst_pkg::REG_TOP, 17'h03FFF);
        write_reg(vst_pkg::REG_WIDTH, 17'd16384);
        write_reg(vst_pkg::REG_HEIGHT, 17'd0);
        write_reg(vst_pkg::REG_NEAR, 17'd65536);
        write_reg(vst_pkg::REG_FAR, 17'd0);
        write_reg(vst_pkg::t_reg'(3'd6), 17'h1FFFF);
        write_reg(vst_pkg::t_reg'(3'd7), 17'h1FFFF);
        // hold the receiver off while words keep coming
        hold_off_left = 400;
        hold_off_armed = 1'b1;
        random_phase(300);
        drain();
        hold_off_armed = 1'b0;

        write_reg(vst_pkg::REG_LEFT, 17'h1C000 | 17'h03FFF);
        write_reg(vst_pkg::REG_TOP, 17'h04000);
        write_reg(vst_pkg::REG_WIDTH, 17'h1FFFF);
        write_reg(vst_pkg::REG_HEIGHT, 17'd16384);
        write_reg(vst_pkg::REG_NEAR, 17'h1FFFF);
        write_reg(vst_pkg::REG_FAR, 17'd12345);
        random_phase(400);
        drain();

        // no idling on either side for a while
        calm_phase = 1'b1;
        write_reg(vst_pkg::REG_LEFT, 17'($urandom));
        write_reg(vst_pkg::REG_TOP, 17'($urandom));
        write_reg(vst_pkg::REG_WIDTH, 17'd640);
        write_reg(vst_pkg::REG_HEIGHT, 17'd480);
        write_reg(vst_pkg::REG_NEAR, 17'd0);
        write_reg(vst_pkg::REG_FAR, 17'd65536);
        random_phase(400);
        drain();
        calm_phase = 1'b0;

        write_reg(vst_pkg::REG_WIDTH, 17'($urandom_range(16384)));
        write_reg(vst_pkg::REG_HEIGHT, 17'($urandom_range(16384)));
        write_reg(vst_pkg::REG_NEAR, 17'($urandom_range(65536)));
        write_reg(vst_pkg::REG_FAR, 17'($urandom_range(65536)));
        random_phase(430);
        drain();

        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
